// ===== src/srt_pkg.sv =====
package srt_pkg;

    // Field widths of the channels and the configuration port.
    localparam int FUNC_W       = 2;
    localparam int NODE_FIELD_W = 6;
    localparam int WEIGHT_W     = 10;
    localparam int STATUS_W     = 2;
    localparam int DIST_FIELD_W = 16;
    localparam int NCFG_W       = 7;
    localparam int LIMIT_W      = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNREACH_LIMIT = 1'd1;

    localparam logic [NCFG_W-1:0]  NODE_COUNT_RESET = 7'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 16'd1000;

    localparam logic [DIST_FIELD_W-1:0] DIST_FIELD_MAX = '1;

    // Function codes.
    localparam logic [FUNC_W-1:0] FUNC_ADD_LINK    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE_LINK = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE     = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_NODE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EXISTS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_LINK  = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [NODE_FIELD_W-1:0] node_a;
        logic [NODE_FIELD_W-1:0] node_b;
        logic [WEIGHT_W-1:0]     weight;
    } srt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [NODE_FIELD_W-1:0] dest_node;
        logic [NODE_FIELD_W-1:0] next_hop;
        logic [DIST_FIELD_W-1:0] distance;
        logic                    reachable;
        logic                    direct;
        logic                    last;
    } srt_out_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LINK_RD,
        S_LINK_CHK,
        S_LINK_WR2,
        S_RESULT,
        S_INIT,
        S_SELECT,
        S_RELAX,
        S_EMIT
    } srt_state_t;

    // Control into the relaxation unit.
    typedef struct packed {
        logic init_mode;
        logic settled_k;
        logic k_is_src;
        logic u_is_src;
    } srt_ctl_t;

    // Decisions out of the relaxation unit.
    typedef struct packed {
        logic wr;
        logic pv_val;
        logic cand;
    } srt_upd_t;

endpackage

// ===== src/srt_relax_unit.sv =====
module srt_relax_unit #(
    parameter int MAX_NODES = 64,
    parameter int DIST_BITS = 16,
    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1,
    localparam int CMP_W  = (DIST_BITS > srt_pkg::LIMIT_W) ? DIST_BITS : srt_pkg::LIMIT_W
) (
    input  srt_pkg::srt_ctl_t             ctl,
    input  logic [srt_pkg::WEIGHT_W-1:0]  weight,
    input  logic [DIST_BITS-1:0]          best_k,
    input  logic [NODE_W-1:0]             fh_k,
    input  logic [NODE_W-1:0]             k,
    input  logic [DIST_BITS-1:0]          best_u,
    input  logic [NODE_W-1:0]             fh_u,
    input  logic [srt_pkg::LIMIT_W-1:0]   limit,
    input  logic [CMP_W-1:0]              sel_cmp,
    output srt_pkg::srt_upd_t             upd,
    output logic [DIST_BITS-1:0]          best_new,
    output logic [NODE_W-1:0]             fh_new
);
    import srt_pkg::*;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    logic [CMP_W-1:0]       limit_ext;
    logic [CMP_W-1:0]       weight_cmp;
    logic [CMP_W-1:0]       init_raw;
    logic [DIST_BITS-1:0]   init_dist;
    logic                   len_ok;
    logic [DIST_BITS:0]     sum;
    logic [DIST_BITS-1:0]   cand_dist;
    logic                   improve;
    logic                   eligible;

    assign limit_ext  = CMP_W'(limit);
    assign weight_cmp = CMP_W'(weight);

    // A missing link stands for the limit distance, saturated to the distance width.
    assign init_raw  = (weight != '0) ? weight_cmp : limit_ext;
    assign init_dist = (init_raw > CMP_W'(DIST_MAX)) ? DIST_MAX : init_raw[DIST_BITS-1:0];

    assign len_ok    = (weight != '0) && (weight_cmp < limit_ext);
    assign sum       = {1'b0, best_u} + (DIST_BITS+1)'(weight);
    assign cand_dist = sum[DIST_BITS] ? DIST_MAX : sum[DIST_BITS-1:0];
    assign improve   = !ctl.settled_k && len_ok && (cand_dist < best_k);

    always_comb begin
        if (ctl.init_mode) begin
            best_new   = ctl.k_is_src ? '0 : init_dist;
            fh_new     = k;
            upd.wr     = 1'b1;
            upd.pv_val = !ctl.k_is_src && (CMP_W'(init_dist) < limit_ext);
            eligible   = !ctl.k_is_src;
        end else begin
            best_new   = improve ? cand_dist : best_k;
            // The first hop of a node reached through the source is the node itself.
            fh_new     = improve ? (ctl.u_is_src ? k : fh_u) : fh_k;
            upd.wr     = improve;
            upd.pv_val = 1'b1;
            eligible   = !ctl.settled_k;
        end
        upd.cand = eligible && (CMP_W'(best_new) < sel_cmp);
    end

endmodule

// ===== src/shortest_path_route_table.sv =====
// Shortest-path route table. The block stores a symmetric table of link weights between
// up to MAX_NODES routers and answers three requests on the s_ channel: add link and
// remove link, which each return one beat with a status, and compute, which runs
// Dijkstra from node_a and returns one beat per node in node order, the final beat
// marked last. After reset the link RAM is cleared one entry per cycle with s_ready low;
// configuration writes are taken throughout. A compute request first runs one scan
// that initializes the distances, then each of the n - 1 iterations spends one
// selection state and one scan that relaxes the chosen node's row and finds the next
// candidate in the same pass, a final selection state follows, and the n results
// stream out one per cycle while the output is not stalled, behind a read of each node.
// The scans are paced by the single read port of the link RAM, which the shared
// relaxation unit visits once per neighbor. The block takes one request at a time;
// s_ready rises again once the last result sits in the output register.
module shortest_path_route_table #(
    parameter int MAX_NODES = 64,
    parameter int DIST_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  srt_pkg::srt_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output srt_pkg::srt_out_t               m_data,
    input  logic                            cfg_we,
    input  logic [srt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [srt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import srt_pkg::*;

    localparam int NODE_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int NCNT_W     = $clog2(MAX_NODES + 1);
    localparam int LINK_AW    = 2 * NODE_W;
    localparam int LINK_DEPTH = 1 << LINK_AW;
    localparam int CMP_W      = (DIST_BITS > LIMIT_W) ? DIST_BITS : LIMIT_W;

    srt_state_t state_reg, state_next;

    logic [LINK_AW-1:0]     clr_addr_reg, clr_addr_next;
    logic [NCFG_W-1:0]      node_count_reg;
    logic [LIMIT_W-1:0]     limit_reg;

    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [NODE_W-1:0]      a_reg, a_next;
    logic [NODE_W-1:0]      b_reg, b_next;
    logic [WEIGHT_W-1:0]    weight_reg, weight_next;
    logic [STATUS_W-1:0]    status_reg, status_next;

    logic [NCNT_W-1:0]      idx_reg, idx_next;
    logic [NCNT_W-1:0]      it_reg, it_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [NODE_W-1:0]      rd_idx_reg, rd_idx_next;

    logic [NODE_W-1:0]      u_reg, u_next;
    logic [DIST_BITS-1:0]   best_u_reg, best_u_next;
    logic [NODE_W-1:0]      fh_u_reg, fh_u_next;

    logic                   sel_found_reg, sel_found_next;
    logic [NODE_W-1:0]      sel_u_reg, sel_u_next;
    logic [NODE_W-1:0]      sel_fh_reg, sel_fh_next;
    logic [CMP_W-1:0]       sel_cmp_reg, sel_cmp_next;

    logic [MAX_NODES-1:0]   settled_reg, settled_next;
    logic [MAX_NODES-1:0]   pv_reg, pv_next;

    logic                   m_valid_reg, m_valid_next;
    srt_out_t               m_data_reg, m_data_next;

    logic [WEIGHT_W-1:0]    link_mem [LINK_DEPTH];
    logic [WEIGHT_W-1:0]    link_rdata_reg;
    logic                   link_we;
    logic                   link_re;
    logic [LINK_AW-1:0]     link_addr;
    logic [WEIGHT_W-1:0]    link_wdata;

    logic [DIST_BITS-1:0]   best_mem [MAX_NODES];
    logic [NODE_W-1:0]      fh_mem [MAX_NODES];
    logic [DIST_BITS-1:0]   best_rdata_reg;
    logic [NODE_W-1:0]      fh_rdata_reg;

    logic [NCNT_W-1:0]      n_eff;
    logic [NCNT_W-1:0]      n_last;
    logic                   s_fire;
    logic                   a_bad;
    logic                   b_bad;
    logic [STATUS_W-1:0]    accept_status;
    logic                   issue_room;
    logic                   out_free;
    logic                   issue;
    logic                   process;
    logic                   consume;
    logic                   emit_load;
    logic                   result_load;
    logic                   link_ok;
    logic [WEIGHT_W-1:0]    link_val;
    logic                   k_is_src;
    logic [CMP_W-1:0]       dist_cmp;
    srt_out_t               emit_data;
    srt_out_t               result_data;

    srt_ctl_t               unit_ctl;
    srt_upd_t               unit_upd;
    logic [DIST_BITS-1:0]   unit_best;
    logic [NODE_W-1:0]      unit_fh;

    // Node count in use, held to 1 .. MAX_NODES.
    always_comb begin
        if (node_count_reg == '0) begin
            n_eff = NCNT_W'(1);
        end else if (node_count_reg > NCFG_W'(MAX_NODES)) begin
            n_eff = NCNT_W'(MAX_NODES);
        end else begin
            n_eff = NCNT_W'(node_count_reg);
        end
    end

    assign n_last = n_eff - NCNT_W'(1);

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign a_bad   = NCFG_W'(s_data.node_a) >= NCFG_W'(n_eff);
    assign b_bad   = NCFG_W'(s_data.node_b) >= NCFG_W'(n_eff);

    always_comb begin
        unique case (s_data.func)
            FUNC_ADD_LINK:    accept_status = (a_bad || b_bad || s_data.weight == '0) ?
                                              ST_BAD_NODE : ST_OK;
            FUNC_REMOVE_LINK: accept_status = (a_bad || b_bad) ? ST_BAD_NODE : ST_OK;
            FUNC_COMPUTE:     accept_status = a_bad ? ST_BAD_NODE : ST_OK;
            default:          accept_status = ST_BAD_NODE;
        endcase
    end

    // Scan pipeline: a read is issued at idx, and its registered data is worked on while rd_vld is set.
    assign issue_room  = idx_reg < n_eff;
    assign out_free    = !m_valid_reg || m_ready;
    assign emit_load   = (state_reg == S_EMIT) && rd_vld_reg && out_free;
    assign result_load = (state_reg == S_RESULT) && out_free;
    assign issue       = ((state_reg == S_INIT || state_reg == S_RELAX) && issue_room) ||
                         (state_reg == S_EMIT && issue_room && (!rd_vld_reg || emit_load));
    assign process     = rd_vld_reg && (state_reg == S_INIT || state_reg == S_RELAX);
    assign consume     = (state_reg == S_EMIT) ? emit_load : rd_vld_reg;
    assign rd_vld_next = issue || (rd_vld_reg && !consume);
    assign rd_idx_next = issue ? idx_reg[NODE_W-1:0] : rd_idx_reg;

    assign link_ok  = (func_reg == FUNC_ADD_LINK) ? (link_rdata_reg == '0) :
                                                    (link_rdata_reg != '0);
    assign link_val = (func_reg == FUNC_ADD_LINK) ? weight_reg : '0;
    assign k_is_src = (rd_idx_reg == a_reg);

    assign unit_ctl.init_mode = (state_reg == S_INIT);
    assign unit_ctl.settled_k = settled_reg[rd_idx_reg];
    assign unit_ctl.k_is_src  = k_is_src;
    assign unit_ctl.u_is_src  = (u_reg == a_reg);

    srt_relax_unit #(
        .MAX_NODES (MAX_NODES),
        .DIST_BITS (DIST_BITS)
    ) u_relax (
        .ctl      (unit_ctl),
        .weight   (link_rdata_reg),
        .best_k   (best_rdata_reg),
        .fh_k     (fh_rdata_reg),
        .k        (rd_idx_reg),
        .best_u   (best_u_reg),
        .fh_u     (fh_u_reg),
        .limit    (limit_reg),
        .sel_cmp  (sel_cmp_reg),
        .upd      (unit_upd),
        .best_new (unit_best),
        .fh_new   (unit_fh)
    );

    // Route result for the node whose data is in the read registers.
    assign dist_cmp = CMP_W'(best_rdata_reg);

    always_comb begin
        emit_data.status    = ST_OK;
        emit_data.dest_node = NODE_FIELD_W'(rd_idx_reg);
        if (k_is_src) begin
            emit_data.next_hop = NODE_FIELD_W'(a_reg);
        end else if (pv_reg[rd_idx_reg]) begin
            emit_data.next_hop = NODE_FIELD_W'(fh_rdata_reg);
        end else begin
            emit_data.next_hop = '0;
        end
        emit_data.distance  = (dist_cmp > CMP_W'(DIST_FIELD_MAX)) ? DIST_FIELD_MAX :
                                                                  dist_cmp[DIST_FIELD_W-1:0];
        emit_data.reachable = dist_cmp < CMP_W'(limit_reg);
        emit_data.direct    = !k_is_src && (link_rdata_reg != '0);
        emit_data.last      = (NCNT_W'(rd_idx_reg) == n_last);
    end

    always_comb begin
        result_data           = '0;
        result_data.status    = status_reg;
        result_data.last      = 1'b1;
    end

    assign m_valid_next = (emit_load || result_load) ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    assign m_data_next  = result_load ? result_data : (emit_load ? emit_data : m_data_reg);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (clr_addr_reg == LINK_AW'(LINK_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    if (accept_status != ST_OK) begin
                        state_next = S_RESULT;
                    end else if (s_data.func == FUNC_COMPUTE) begin
                        state_next = S_INIT;
                    end else begin
                        state_next = S_LINK_RD;
                    end
                end
            end
            S_LINK_RD:  state_next = S_LINK_CHK;
            S_LINK_CHK: state_next = link_ok ? S_LINK_WR2 : S_RESULT;
            S_LINK_WR2: state_next = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            S_INIT, S_RELAX: begin
                if (!issue_room) begin
                    state_next = S_SELECT;
                end
            end
            S_SELECT:   state_next = (it_reg < n_last) ? S_RELAX : S_EMIT;
            S_EMIT: begin
                if (emit_load && emit_data.last) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb begin
        clr_addr_next  = clr_addr_reg;
        func_next      = func_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        weight_next    = weight_reg;
        status_next    = status_reg;
        idx_next       = idx_reg;
        it_next        = it_reg;
        u_next         = u_reg;
        best_u_next    = best_u_reg;
        fh_u_next      = fh_u_reg;
        sel_found_next = sel_found_reg;
        sel_u_next     = sel_u_reg;
        sel_fh_next    = sel_fh_reg;
        sel_cmp_next   = sel_cmp_reg;
        settled_next   = settled_reg;
        pv_next        = pv_reg;
        link_we        = 1'b0;
        link_re        = 1'b0;
        link_addr      = {a_reg, b_reg};
        link_wdata     = link_val;

        unique case (state_reg)
            S_CLEAR: begin
                link_we       = 1'b1;
                link_addr     = clr_addr_reg;
                link_wdata    = '0;
                clr_addr_next = clr_addr_reg + LINK_AW'(1);
            end
            S_IDLE: begin
                if (s_fire) begin
                    func_next      = s_data.func;
                    a_next         = s_data.node_a[NODE_W-1:0];
                    b_next         = s_data.node_b[NODE_W-1:0];
                    weight_next    = s_data.weight;
                    status_next    = accept_status;
                    idx_next       = '0;
                    it_next        = '0;
                    sel_found_next = 1'b0;
                    sel_cmp_next   = CMP_W'(limit_reg);
                    settled_next   = '0;
                    settled_next[s_data.node_a[NODE_W-1:0]] = 1'b1;
                end
            end
            S_LINK_RD: begin
                link_re = 1'b1;
            end
            S_LINK_CHK: begin
                if (link_ok) begin
                    link_we = 1'b1;
                end else begin
                    status_next = (func_reg == FUNC_ADD_LINK) ? ST_EXISTS : ST_NO_LINK;
                end
            end
            S_LINK_WR2: begin
                link_we   = 1'b1;
                link_addr = {b_reg, a_reg};
            end
            S_INIT, S_RELAX, S_EMIT: begin
                link_re   = issue;
                link_addr = {(state_reg == S_RELAX) ? u_reg : a_reg, idx_reg[NODE_W-1:0]};
                if (issue) begin
                    idx_next = idx_reg + NCNT_W'(1);
                end
            end
            S_SELECT: begin
                idx_next = '0;
                if (it_reg < n_last) begin
                    // With no candidate below the limit the source is chosen again,
                    // and its relaxation pass changes nothing.
                    u_next         = sel_found_reg ? sel_u_reg : a_reg;
                    best_u_next    = sel_found_reg ? sel_cmp_reg[DIST_BITS-1:0] : '0;
                    fh_u_next      = sel_fh_reg;
                    settled_next[u_next] = 1'b1;
                    it_next        = it_reg + NCNT_W'(1);
                    sel_found_next = 1'b0;
                    sel_cmp_next   = CMP_W'(limit_reg);
                end
            end
            default: ;
        endcase

        if (process && unit_upd.wr) begin
            pv_next[rd_idx_reg] = unit_upd.pv_val;
        end
        if (process && unit_upd.cand) begin
            sel_found_next = 1'b1;
            sel_u_next     = rd_idx_reg;
            sel_fh_next    = unit_fh;
            sel_cmp_next   = CMP_W'(unit_best);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            rd_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            sel_found_reg  <= 1'b0;
            settled_reg    <= '0;
            pv_reg         <= '0;
            node_count_reg <= NODE_COUNT_RESET;
            limit_reg      <= LIMIT_RESET;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            rd_vld_reg    <= rd_vld_next;
            m_valid_reg   <= m_valid_next;
            sel_found_reg <= sel_found_next;
            settled_reg   <= settled_next;
            pv_reg        <= pv_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_NODE_COUNT:    node_count_reg <= cfg_wdata[NCFG_W-1:0];
                    CFG_UNREACH_LIMIT: limit_reg      <= cfg_wdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        weight_reg  <= weight_next;
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        it_reg      <= it_next;
        rd_idx_reg  <= rd_idx_next;
        u_reg       <= u_next;
        best_u_reg  <= best_u_next;
        fh_u_reg    <= fh_u_next;
        sel_u_reg   <= sel_u_next;
        sel_fh_reg  <= sel_fh_next;
        sel_cmp_reg <= sel_cmp_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_addr] <= link_wdata;
        end
        if (link_re) begin
            link_rdata_reg <= link_mem[link_addr];
        end
    end

    // Per-node distance and first-hop stores, written by the initialization scan and the relaxation pass.
    always_ff @(posedge aclk) begin
        if (process && unit_upd.wr) begin
            best_mem[rd_idx_reg] <= unit_best;
            fh_mem[rd_idx_reg]   <= unit_fh;
        end
        if (issue) begin
            best_rdata_reg <= best_mem[idx_reg[NODE_W-1:0]];
            fh_rdata_reg   <= fh_mem[idx_reg[NODE_W-1:0]];
        end
    end

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE) |-> !rd_vld_reg)
        else $error("scan read still in flight while idle");

    a_relax_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RELAX) |-> (settled_reg[u_reg] && settled_reg[a_reg]))
        else $error("relaxing from a node that is not settled");

    a_last_ends_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_load && emit_data.last) |=> (state_reg == S_IDLE) && m_valid_reg && m_data.last)
        else $error("last route beat did not end the request");

    a_result_single: assert property (@(posedge aclk) disable iff (!aresetn)
        result_load |=> (state_reg == S_IDLE) && m_valid_reg && m_data.last)
        else $error("status beat not delivered as a single last beat");

endmodule

// ===== bench/shortest_path_route_table_tb.sv =====
`timescale 1ns / 1ps

module shortest_path_route_table_tb;
    import srt_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int MAX_NODES       = 64;
    localparam int WATCHDOG_LIMIT  = 30000;
    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 16;
    localparam int MAX_PRINTED     = 40;
    localparam int DIR_ROWS        = 25;

    typedef struct packed {
        logic [NCFG_W-1:0]   nodes;
        logic [LIMIT_W-1:0]  lim;
        srt_in_t             req;
        logic                typed;
        logic [STATUS_W-1:0] status;
    } dir_row_t;

    // Directed requests. Rows with typed set carry their status; the rest are predicted.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{7'd64, 16'd1000, '{FUNC_COMPUTE,     6'd0,  6'd0,  10'd0},    1'b0, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd63, 10'd999},  1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd63, 6'd0,  10'd5},    1'b1, ST_EXISTS},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd1,  10'd0},    1'b1, ST_BAD_NODE},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd5,  6'd5,  10'd7},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_REMOVE_LINK, 6'd2,  6'd3,  10'd0},    1'b1, ST_NO_LINK},
        '{7'd64, 16'd1000, '{FUNC_UNUSED,      6'd63, 6'd63, 10'd1023}, 1'b1, ST_BAD_NODE},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd1,  10'd1},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd1,  6'd2,  10'd1},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd2,  6'd63, 10'd1},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd2,  10'd3},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd3,  10'd2},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd1,  6'd3,  10'd1},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_COMPUTE,     6'd63, 6'd17, 10'd512},  1'b0, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_REMOVE_LINK, 6'd63, 6'd0,  10'd0},    1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_ADD_LINK,    6'd0,  6'd0,  10'd1023}, 1'b1, ST_OK},
        '{7'd64, 16'd1000, '{FUNC_COMPUTE,     6'd0,  6'd0,  10'd0},    1'b0, ST_OK},
        '{7'd4,  16'd1,    '{FUNC_ADD_LINK,    6'd0,  6'd5,  10'd10},   1'b1, ST_BAD_NODE},
        '{7'd4,  16'd1,    '{FUNC_COMPUTE,     6'd4,  6'd0,  10'd0},    1'b1, ST_BAD_NODE},
        '{7'd4,  16'd1,    '{FUNC_COMPUTE,     6'd1,  6'd0,  10'd0},    1'b0, ST_OK},
        '{7'd3,  16'd2,    '{FUNC_COMPUTE,     6'd0,  6'd0,  10'd0},    1'b0, ST_OK},
        '{7'd1,  16'd65535,'{FUNC_COMPUTE,     6'd0,  6'd0,  10'd0},    1'b0, ST_OK},
        '{7'd1,  16'd65535,'{FUNC_ADD_LINK,    6'd0,  6'd0,  10'd4},    1'b1, ST_EXISTS},
        '{7'd1,  16'd65535,'{FUNC_REMOVE_LINK, 6'd0,  6'd1,  10'd0},    1'b1, ST_BAD_NODE},
        '{7'd1,  16'd65535,'{FUNC_REMOVE_LINK, 6'd0,  6'd0,  10'd0},    1'b1, ST_OK}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    srt_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    srt_out_t              m_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // Mirror of the block's state and registers.
    logic [WEIGHT_W-1:0] link_wt [MAX_NODES*MAX_NODES];
    logic [NCFG_W-1:0]   node_count_reg = NODE_COUNT_RESET;
    logic [LIMIT_W-1:0]  limit_reg      = LIMIT_RESET;

    srt_out_t route_beats_due [$];
    int       error_count = 0;
    bit       steady      = 1'b0;
    int       stall_left  = 0;

    shortest_path_route_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int active_nodes();
        if (node_count_reg == 0) return 1;
        if (node_count_reg > MAX_NODES) return MAX_NODES;
        return int'(node_count_reg);
    endfunction

    function automatic int unsigned clip_dist(int unsigned v);
        return (v > 32'(DIST_FIELD_MAX)) ? 32'(DIST_FIELD_MAX) : v;
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want, int dest);
        if (got !== want)
            report_error($sformatf("dest %0d %s: got %0d, expected %0d", dest, name, got, want));
    endtask

    // Dijkstra from src over the first n nodes; queues one route beat per node.
    task automatic compute_routes(int src, int n);
        bit              settled  [MAX_NODES];
        bit              pv       [MAX_NODES];
        int unsigned     path_len [MAX_NODES];
        int              pred     [MAX_NODES];
        int unsigned     lim, bd, len, cand;
        int              u, c, steps;
        logic [WEIGHT_W-1:0] w;
        srt_out_t        beat;
        lim = 32'(limit_reg);
        for (int i = 0; i < n; i++) begin
            w = link_wt[src*MAX_NODES + i];
            settled[i] = 1'b0;
            path_len[i] = clip_dist((w != 0) ? 32'(w) : lim);
            pv[i] = (i != src) && (path_len[i] < lim);
            pred[i] = pv[i] ? src : 0;
        end
        settled[src] = 1'b1;
        path_len[src] = 0;
        pv[src] = 1'b0;
        for (int it = 0; it + 1 < n; it++) begin
            bd = lim;
            u = src;
            for (int i = 0; i < n; i++) begin
                if (!settled[i] && path_len[i] < bd) begin
                    u = i;
                    bd = path_len[i];
                end
            end
            settled[u] = 1'b1;
            for (int k = 0; k < n; k++) begin
                w = link_wt[u*MAX_NODES + k];
                len = (w != 0) ? 32'(w) : lim;
                if (!settled[k] && len < lim) begin
                    cand = clip_dist(path_len[u] + len);
                    if (cand < path_len[k]) begin
                        path_len[k] = cand;
                        pred[k] = u;
                        pv[k] = 1'b1;
                    end
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            beat = '0;
            beat.status = ST_OK;
            beat.dest_node = NODE_FIELD_W'(i);
            beat.distance = DIST_FIELD_W'(clip_dist(path_len[i]));
            beat.reachable = path_len[i] < lim;
            beat.direct = (i != src) && (link_wt[src*MAX_NODES + i] != 0);
            beat.last = (i + 1 == n);
            if (i == src) begin
                beat.next_hop = NODE_FIELD_W'(src);
            end else if (pv[i]) begin
                // Walk predecessors back until the node right after the source.
                c = i;
                steps = 0;
                while (pv[c] && pred[c] != src && steps < MAX_NODES) begin
                    c = pred[c];
                    steps++;
                end
                beat.next_hop = NODE_FIELD_W'(c);
            end
            route_beats_due.push_back(beat);
        end
    endtask

    task automatic predict_request(srt_in_t req);
        int                  n, a, b;
        logic [STATUS_W-1:0] st;
        srt_out_t            beat;
        n = active_nodes();
        a = int'(req.node_a);
        b = int'(req.node_b);
        st = ST_BAD_NODE;
        case (req.func)
            FUNC_ADD_LINK: begin
                if (a >= n || b >= n || req.weight == 0) begin
                    st = ST_BAD_NODE;
                end else if (link_wt[a*MAX_NODES + b] != 0) begin
                    st = ST_EXISTS;
                end else begin
                    link_wt[a*MAX_NODES + b] = req.weight;
                    link_wt[b*MAX_NODES + a] = req.weight;
                    st = ST_OK;
                end
            end
            FUNC_REMOVE_LINK: begin
                if (a >= n || b >= n) begin
                    st = ST_BAD_NODE;
                end else if (link_wt[a*MAX_NODES + b] == 0) begin
                    st = ST_NO_LINK;
                end else begin
                    link_wt[a*MAX_NODES + b] = '0;
                    link_wt[b*MAX_NODES + a] = '0;
                    st = ST_OK;
                end
            end
            FUNC_COMPUTE: begin
                if (a < n) begin
                    compute_routes(a, n);
                    return;
                end
            end
            default: ;
        endcase
        beat = '0;
        beat.status = st;
        beat.last = 1'b1;
        route_beats_due.push_back(beat);
    endtask

    // Presents one request beat and queues its results once it is taken.
    task automatic send_request(srt_in_t req, bit typed, logic [STATUS_W-1:0] status);
        srt_out_t beat;
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_request(req);
        if (typed) begin
            beat = '0;
            beat.status = status;
            beat.last = 1'b1;
            route_beats_due[route_beats_due.size() - 1] = beat;
        end
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (route_beats_due.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    task automatic set_phase(int nodes, int lim);
        cfg_we <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_wdata <= CFG_DATA_W'(nodes);
        @(posedge aclk);
        node_count_reg = NCFG_W'(nodes);
        cfg_index <= CFG_UNREACH_LIMIT;
        cfg_wdata <= CFG_DATA_W'(lim);
        @(posedge aclk);
        limit_reg = LIMIT_W'(lim);
        cfg_we <= 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        srt_out_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (route_beats_due.size() == 0) begin
                report_error($sformatf("result beat for dest %0d with nothing expected",
                                       m_data.dest_node));
            end else begin
                want = route_beats_due.pop_front();
                check_field("status",    32'(m_data.status),    32'(want.status),
                            int'(want.dest_node));
                check_field("dest_node", 32'(m_data.dest_node), 32'(want.dest_node),
                            int'(want.dest_node));
                check_field("next_hop",  32'(m_data.next_hop),  32'(want.next_hop),
                            int'(want.dest_node));
                check_field("distance",  32'(m_data.distance),  32'(want.distance),
                            int'(want.dest_node));
                check_field("reachable", 32'(m_data.reachable), 32'(want.reachable),
                            int'(want.dest_node));
                check_field("direct",    32'(m_data.direct),    32'(want.direct),
                            int'(want.dest_node));
                check_field("last",      32'(m_data.last),      32'(want.last),
                            int'(want.dest_node));
            end
        end
        if (!steady && stall_left == 0 && $urandom_range(0, 15) == 0)
            stall_left = $urandom_range(1, 17);
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("shortest_path_route_table_tb NOT OK");
        $finish;
    end

    initial begin : stimulus
        srt_in_t req;
        int      n, lim, a, b, pick, tries;
        foreach (link_wt[i]) link_wt[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].nodes != node_count_reg || DIR_TABLE[r].lim != limit_reg) begin
                settle_idle();
                set_phase(int'(DIR_TABLE[r].nodes), int'(DIR_TABLE[r].lim));
            end
            send_request(DIR_TABLE[r].req, DIR_TABLE[r].typed, DIR_TABLE[r].status);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 2)
                n = MAX_NODES;
            else if ($urandom_range(0, 5) == 0)
                n = 1;
            else
                n = $urandom_range(2, 12);
            case ($urandom_range(0, 4))
                0: lim = 1;
                1: lim = $urandom_range(2, 80);
                2: lim = 1000;
                3: lim = 65535;
                default: lim = $urandom_range(1, 65535);
            endcase
            settle_idle();
            set_phase(n, lim);
            // The closing phase runs with both sides always ready.
            steady = (p == RANDOM_PHASES - 1);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                pick = $urandom_range(0, 99);
                a = $urandom_range(0, n - 1);
                b = $urandom_range(0, n - 1);
                req = '0;
                if (pick < 35) begin
                    req.func = FUNC_ADD_LINK;
                    req.weight = ($urandom_range(0, 2) == 0) ? WEIGHT_W'($urandom_range(1, 999))
                                                            : WEIGHT_W'($urandom_range(1, 60));
                end else if (pick < 50) begin
                    // Prefer a link that is present so the removal takes effect.
                    tries = 0;
                    while (link_wt[a*MAX_NODES + b] == 0 && tries < 16) begin
                        a = $urandom_range(0, n - 1);
                        b = $urandom_range(0, n - 1);
                        tries++;
                    end
                    req.func = FUNC_REMOVE_LINK;
                    req.weight = WEIGHT_W'($urandom_range(0, 1023));
                end else if (pick < 75) begin
                    req.func = FUNC_COMPUTE;
                    b = $urandom_range(0, 63);
                    req.weight = WEIGHT_W'($urandom_range(0, 1023));
                end else begin
                    req.func = FUNC_W'($urandom_range(0, 3));
                    a = $urandom_range(0, 63);
                    b = $urandom_range(0, 63);
                    req.weight = WEIGHT_W'($urandom_range(0, 1023));
                end
                req.node_a = NODE_FIELD_W'(a);
                req.node_b = NODE_FIELD_W'(b);
                send_request(req, 1'b0, ST_OK);
            end
        end

        settle_idle();
        repeat (48) @(posedge aclk);
        if (error_count == 0 && route_beats_due.size() == 0) begin
            $display("shortest_path_route_table_tb OK");
        end else begin
            $display("shortest_path_route_table_tb NOT OK");
        end
        $finish;
    end

endmodule
